[hdl/lbas_pkg.sv]
// Package for the LED bar animation sequencer.
// Holds the pattern and register codes, the state and configuration types
// and the small helper functions. Depends on nothing.
package lbas_pkg;

  localparam int NumLeds = 8;

  typedef enum logic [2:0] {
    PAT_SWEEP     = 3'd0,
    PAT_FADE      = 3'd1,
    PAT_FILL      = 3'd2,
    PAT_DOMINATOR = 3'd3,
    PAT_TRAVEL    = 3'd4,
    PAT_ALL_OFF   = 3'd5,
    PAT_ALL_ON    = 3'd6
  } pattern_t;

  typedef enum logic [1:0] {
    REG_PATTERN_SELECT = 2'd0,
    REG_MODE_BITS      = 2'd1,
    REG_FULL_SCALE     = 2'd2,
    REG_ALPHA_LEVEL    = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] ModeForeground = 8'h01;
  localparam logic [7:0] ModeFullOn     = 8'h10;

  typedef struct packed {
    logic [2:0] pattern_select;
    logic [7:0] mode_bits;
    logic [7:0] full_scale;
    logic [7:0] alpha_level;
  } cfg_t;

  typedef struct packed {
    logic [NumLeds-1:0][7:0] levels;
    logic [7:0]              tick_delay;
    logic [5:0]              frame_index;
    logic [6:0]              delay_limit;
    logic                    started;
  } state_t;

  function automatic logic [6:0] init_limit(input logic [2:0] pat);
    logic [6:0] lim;
    unique case (pat)
      PAT_FILL:   lim = 7'd60;
      PAT_TRAVEL: lim = 7'd127;
      PAT_SWEEP, PAT_FADE, PAT_DOMINATOR: lim = 7'd30;
      default:    lim = 7'd35;
    endcase
    return lim;
  endfunction

  function automatic logic [7:0] sweep_feed(input logic [2:0] idx, input logic [7:0] m,
                                            input logic [7:0] b);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = m;
      3'd1:    v = m >> 2;
      3'd2:    v = m >> 5;
      default: v = b;
    endcase
    return v;
  endfunction

endpackage

[hdl/lbas_step.sv]
// Next-state logic of the LED bar animation sequencer for one tick.
// Purely combinational; uses lbas_pkg for the state and configuration types.
module lbas_step (
  input  lbas_pkg::cfg_t   cfg,
  input  lbas_pkg::state_t cur,
  input  logic             restart,
  output lbas_pkg::state_t nxt
);

  lbas_pkg::state_t s;
  logic [7:0] m;
  logic [7:0] b;
  logic [7:0] td_inc;
  logic [5:0] fi_inc;
  logic [5:0] fi_half;
  logic [7:0] feed;
  logic [5:0] fi_trav;
  logic [5:0] fi_prev;
  logic       delay_hit;
  logic [7:0] h, q, e, sx, t, x;

  assign m = cfg.full_scale;
  assign b = ((cfg.mode_bits & lbas_pkg::ModeForeground) != 8'd0) ? cfg.alpha_level : 8'd0;
  assign h  = m >> 1;
  assign q  = m >> 2;
  assign e  = m >> 3;
  assign sx = m >> 4;
  assign t  = m >> 5;
  assign x  = m >> 6;

  always_comb begin
    s = cur;
    if (restart || !cur.started) begin
      s.levels      = '0;
      s.tick_delay  = '0;
      s.frame_index = '0;
      s.delay_limit = lbas_pkg::init_limit(cfg.pattern_select);
      s.started     = 1'b1;
    end

    delay_hit = (s.tick_delay == {1'b0, s.delay_limit});
    td_inc    = s.tick_delay + 8'd1;
    fi_inc    = s.frame_index + 6'd1;
    fi_half   = s.frame_index - 6'd12;
    feed      = b;
    fi_trav   = s.frame_index;
    fi_prev   = '0;
    nxt       = s;

    unique case (cfg.pattern_select)
      lbas_pkg::PAT_SWEEP: begin
        if (!delay_hit) begin
          nxt.tick_delay = td_inc;
        end else begin
          nxt.tick_delay = '0;
          if (s.frame_index < 6'd12) begin
            feed = (s.frame_index < 6'd8) ?
                   lbas_pkg::sweep_feed(s.frame_index[2:0], m, b) : b;
            for (int i = 7; i > 0; i--) begin
              nxt.levels[i] = s.levels[i-1];
            end
            nxt.levels[0]   = feed;
            nxt.frame_index = fi_inc;
          end else if (s.frame_index < 6'd32) begin
            feed = (s.frame_index < 6'd20) ? lbas_pkg::sweep_feed(fi_half[2:0], m, b) : b;
            for (int i = 0; i < 7; i++) begin
              nxt.levels[i] = s.levels[i+1];
            end
            nxt.levels[7]   = feed;
            nxt.frame_index = fi_inc;
          end else begin
            nxt.frame_index = '0;
          end
        end
      end
      lbas_pkg::PAT_FADE: begin
        if (!delay_hit) begin
          nxt.tick_delay = td_inc;
        end else begin
          nxt.tick_delay = '0;
          for (int i = 0; i < 8; i++) begin
            nxt.levels[i] = (s.frame_index == 6'd0) ? s.levels[i] + 8'd1 : s.levels[i] - 8'd1;
          end
          if (nxt.levels[0] == q) begin
            nxt.frame_index = 6'd1;
          end else if (nxt.levels[0] == 8'd0) begin
            nxt.frame_index = 6'd0;
          end
        end
      end
      lbas_pkg::PAT_FILL: begin
        if (s.frame_index < 6'd8) begin
          nxt.levels[s.frame_index[2:0]] = sx;
        end
        if (s.frame_index >= 6'd15) begin
          nxt.frame_index = '0;
          nxt.levels      = '0;
        end else if (delay_hit) begin
          nxt.frame_index = fi_inc;
          nxt.tick_delay  = '0;
        end else begin
          nxt.tick_delay = td_inc;
        end
      end
      lbas_pkg::PAT_DOMINATOR: begin
        if (!delay_hit) begin
          nxt.tick_delay = td_inc;
        end else begin
          nxt.levels = {x, x, sx, q, q, sx, x, x};
          unique case (s.frame_index)
            6'd0: begin
              nxt.levels[3] = h; nxt.levels[4] = h;
            end
            6'd1: begin
              nxt.levels[2] = h; nxt.levels[5] = h;
            end
            6'd2: begin
              nxt.levels[1] = h; nxt.levels[2] = e; nxt.levels[3] = sx;
              nxt.levels[4] = sx; nxt.levels[5] = e; nxt.levels[6] = h;
            end
            6'd3: begin
              nxt.levels = {h, e, t, e, e, t, e, h};
            end
            6'd4: begin
              nxt.levels[0] = e; nxt.levels[1] = t;
              nxt.levels[6] = t; nxt.levels[7] = e;
            end
            6'd5: begin
              nxt.levels[0] = t; nxt.levels[7] = t;
            end
            default: begin
            end
          endcase
          nxt.tick_delay  = '0;
          nxt.frame_index = (fi_inc > 6'd6) ? 6'd0 : fi_inc;
        end
      end
      lbas_pkg::PAT_TRAVEL: begin
        if (td_inc >= {1'b0, s.delay_limit}) begin
          nxt.tick_delay = '0;
          fi_trav        = fi_inc;
        end else begin
          nxt.tick_delay = td_inc;
        end
        fi_prev = fi_trav - 6'd1;
        if (fi_trav < 6'd8) begin
          nxt.levels[fi_trav[2:0]] = m;
        end
        if (fi_trav != 6'd0 && fi_trav <= 6'd8) begin
          nxt.levels[fi_prev[2:0]] = 8'd0;
        end
        nxt.frame_index = (fi_trav >= 6'd8) ? 6'd0 : fi_trav;
      end
      lbas_pkg::PAT_ALL_OFF: begin
        nxt.levels = {lbas_pkg::NumLeds{b}};
      end
      default: begin
        nxt.levels = {lbas_pkg::NumLeds{(cfg.mode_bits == lbas_pkg::ModeFullOn) ? m : h}};
      end
    endcase
  end

endmodule

[hdl/led_bar_animation_sequencer.sv]
// Top level of the LED bar animation sequencer: configuration registers,
// state registers and the item handshakes. Uses lbas_pkg and lbas_step.
//
// Each accepted item is one animation tick and yields exactly one result
// item carrying all eight LED levels. The whole update of a tick runs
// through lbas_step into the state registers, which also serve as the
// result register, so one tick can be accepted every cycle while the
// output side keeps taking results. A new tick is held off only while a
// result is waiting and the output is stalled. The first tick after reset,
// or any tick with restart set, starts a fresh frame of the selected pattern.
module led_bar_animation_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] level_0,
  output logic [7:0] level_1,
  output logic [7:0] level_2,
  output logic [7:0] level_3,
  output logic [7:0] level_4,
  output logic [7:0] level_5,
  output logic [7:0] level_6,
  output logic [7:0] level_7
);

  lbas_pkg::cfg_t   cfg;
  lbas_pkg::state_t state;
  lbas_pkg::state_t state_next;
  logic             in_take;

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_select <= lbas_pkg::PAT_ALL_ON;
      cfg.mode_bits      <= 8'd0;
      cfg.full_scale     <= 8'd255;
      cfg.alpha_level    <= 8'd0;
    end else if (cfg_we) begin
      unique case (lbas_pkg::cfg_reg_t'(cfg_index))
        lbas_pkg::REG_PATTERN_SELECT: cfg.pattern_select <= cfg_data[2:0];
        lbas_pkg::REG_MODE_BITS:      cfg.mode_bits      <= cfg_data;
        lbas_pkg::REG_FULL_SCALE:     cfg.full_scale     <= cfg_data;
        lbas_pkg::REG_ALPHA_LEVEL:    cfg.alpha_level    <= cfg_data;
      endcase
    end
  end

  lbas_step u_step (
    .cfg     (cfg),
    .cur     (state),
    .restart (restart),
    .nxt     (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        state <= state_next;
      end
      if (in_take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign level_0 = state.levels[0];
  assign level_1 = state.levels[1];
  assign level_2 = state.levels[2];
  assign level_3 = state.levels[3];
  assign level_4 = state.levels[4];
  assign level_5 = state.levels[5];
  assign level_6 = state.levels[6];
  assign level_7 = state.levels[7];

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_take |=> out_valid)
    else $error("accepted tick produced no result");

  a_levels_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(state.levels))
    else $error("levels changed while a result was waiting");

  a_restart_delay: assert property (@(posedge clk) disable iff (rst)
    (in_take && restart) |=> (state.started && state.tick_delay <= 8'd1))
    else $error("restart did not reinitialise the tick delay");
`endif

endmodule
